// ===== hw/rtl/lmts_pkg.sv =====
`timescale 1ns / 1ps
package lmts_pkg;

	// glyph geometry
	localparam int GLYPH_ROWS = 8;
	localparam int ROW_W      = 3;

	// request codes
	localparam logic [1:0] REQ_TICK    = 2'd0;
	localparam logic [1:0] REQ_LOAD    = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	// scroll directions
	localparam logic [1:0] DIR_LEFT  = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_UP    = 2'd3;

	// result status codes
	localparam logic [1:0] ST_WAITED = 2'd0;
	localparam logic [1:0] ST_PAUSED = 2'd1;
	localparam logic [1:0] ST_MOVED  = 2'd2;
	localparam logic [1:0] ST_ENDED  = 2'd3;

	// configuration register map
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MSG_LEN     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP        = 2'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [1:0] direction;
		logic [7:0] char_index;
		logic [2:0] glyph_row;
		logic [7:0] glyph_byte;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] row_index;
		logic [7:0] row_byte;
		logic       last;
	} res_t;

endpackage

// ===== hw/rtl/lmts_cmd_if.sv =====
`timescale 1ns / 1ps
interface lmts_cmd_if;
	import lmts_pkg::*;

	logic valid;
	logic ready;
	cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lmts_res_if.sv =====
`timescale 1ns / 1ps
interface lmts_res_if;
	import lmts_pkg::*;

	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lmts_ram.sv =====
`timescale 1ns / 1ps
module lmts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/led_matrix_text_scroller.sv =====
`timescale 1ns / 1ps
// A tick is judged the cycle after its transaction; a wait, pause or end result
// is then registered from S_STAT. A move shifts the frame in S_SHIFT, with a glyph fetch
// in S_FETCH before or after it, and gives its rows from S_EMIT one per cycle while the
// output is not stalled. One command at a time: commands are taken only in S_IDLE, where
// loads and restarts finish; a move makes at most one glyph fetch.
// Reset: scroll state and frame clear at once; the glyph memory is not cleared.
module led_matrix_text_scroller #(
	parameter int MAX_CHARS = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lmts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lmts_pkg::CFG_DATA_W-1:0] cfg_wdata,
	lmts_cmd_if.sink                       cmd,
	lmts_res_if.source                     res
);
	import lmts_pkg::*;

	localparam int CW    = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
	localparam int AW    = CW + ROW_W;
	localparam int DEPTH = MAX_CHARS * GLYPH_ROWS;
	localparam logic [10:0] MAX_CHARS_W = 11'(MAX_CHARS);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EVAL  = 3'd1;
	localparam logic [2:0] S_FETCH = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;
	localparam logic [2:0] S_STAT  = 3'd5;

	function automatic logic [7:0] bit_rev(input logic [7:0] v);
		logic [7:0] r;
		for (int b = 0; b < 8; b++) begin
			r[b] = v[7-b];
		end
		return r;
	endfunction

	// configuration registers
	logic [15:0] step_period_q;
	logic [15:0] pause_ms_q;
	logic [7:0]  msg_len_q;
	logic        flip_q;

	// scroll state
	logic [2:0]  state_q;
	logic [31:0] now_q;
	logic [31:0] last_q;
	logic [31:0] pstart_q;
	logic        pausing_q;
	logic [8:0]  pos_q;
	logic [2:0]  col_q;
	logic        first_q;
	logic [1:0]  dir_q;
	logic [3:0]  fcnt_q;
	logic        blank_q;
	logic        post_q;
	logic [2:0]  emit_q;
	logic [1:0]  stat_q;
	logic [7:0]  frame_q [16];
	logic        cap_v_s1;
	logic [2:0]  cap_row_s1;
	logic        res_valid_q;
	res_t        res_data_q;

	// glyph memory signals
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	logic        cmd_acc;
	logic        step_due;
	logic        pause_done;
	logic        at_end;
	logic        blank_now;
	logic        slot_free;
	logic        res_load;
	logic [2:0]  rd_sel;
	logic [7:0]  rd_row;
	logic [7:0]  shifted [16];
	logic [9:0]  ci_ext;
	logic [9:0]  pos_ext;

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;

	// timing compares, modulo 2^32
	assign step_due   = (now_q - last_q) > {16'd0, step_period_q};
	assign pause_done = (now_q - pstart_q) > {16'd0, pause_ms_q};

	// fetch position checks
	assign at_end    = (pos_q == {1'b0, msg_len_q});
	assign blank_now = (pos_q >= {1'b0, msg_len_q}) || ({2'b00, pos_q} >= MAX_CHARS_W);

	// glyph memory addressing
	assign ci_ext    = {2'b00, cmd.data.char_index};
	assign pos_ext   = {1'b0, pos_q};
	assign ram_we    = cmd_acc && (cmd.data.req_type == REQ_LOAD)
		&& ({1'b0, ci_ext} < MAX_CHARS_W);
	assign ram_waddr = {ci_ext[CW-1:0], cmd.data.glyph_row};
	assign ram_raddr = {pos_ext[CW-1:0], fcnt_q[2:0]};

	lmts_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_glyph_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cmd.data.glyph_byte),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// one-pixel frame shift
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			shifted[i] = frame_q[i];
		end
		unique case (dir_q)
			DIR_LEFT: begin
				for (int i = 0; i < 8; i++) begin
					shifted[i]   = {frame_q[i][6:0], frame_q[i+8][7]};
					shifted[i+8] = {frame_q[i+8][6:0], 1'b0};
				end
			end
			DIR_RIGHT: begin
				for (int i = 0; i < 8; i++) begin
					shifted[i]   = {frame_q[i+8][0], frame_q[i][7:1]};
					shifted[i+8] = {1'b0, frame_q[i+8][7:1]};
				end
			end
			DIR_DOWN: begin
				for (int i = 1; i < 8; i++) begin
					shifted[i]   = frame_q[i-1];
					shifted[i+8] = frame_q[i+7];
				end
				shifted[0] = frame_q[15];
				shifted[8] = 8'd0;
			end
			DIR_UP: begin
				for (int i = 0; i < 15; i++) begin
					shifted[i] = frame_q[i+1];
				end
				shifted[15] = 8'd0;
			end
		endcase
	end

	// display row selection
	assign rd_sel = flip_q ? emit_q : ~emit_q;
	assign rd_row = flip_q ? frame_q[{1'b0, rd_sel}] : bit_rev(frame_q[{1'b0, rd_sel}]);

	assign slot_free = !res_valid_q || res.ready;
	assign res_load  = slot_free && ((state_q == S_EMIT) || (state_q == S_STAT));

	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_period_q <= 16'd100;
			pause_ms_q    <= 16'd1000;
			msg_len_q     <= 8'd0;
			flip_q        <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEP_PERIOD: step_period_q <= cfg_wdata;
				REG_PAUSE:       pause_ms_q    <= cfg_wdata;
				REG_MSG_LEN:     msg_len_q     <= cfg_wdata[7:0];
				REG_FLIP:        flip_q        <= cfg_wdata[0];
			endcase
		end
	end

	// scroll sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			now_q      <= 32'd0;
			last_q     <= 32'd0;
			pstart_q   <= 32'd0;
			pausing_q  <= 1'b0;
			pos_q      <= 9'd0;
			col_q      <= 3'd0;
			first_q    <= 1'b0;
			dir_q      <= DIR_LEFT;
			fcnt_q     <= 4'd0;
			blank_q    <= 1'b0;
			post_q     <= 1'b0;
			emit_q     <= 3'd0;
			stat_q     <= ST_WAITED;
			cap_v_s1   <= 1'b0;
			cap_row_s1 <= 3'd0;
			for (int i = 0; i < 16; i++) begin
				frame_q[i] <= 8'd0;
			end
		end else begin
			cap_v_s1   <= (state_q == S_FETCH) && !fcnt_q[3];
			cap_row_s1 <= fcnt_q[2:0];
			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						priority case (cmd.data.req_type)
							REQ_TICK: begin
								now_q   <= now_q + 32'd1;
								dir_q   <= cmd.data.direction;
								state_q <= S_EVAL;
							end
							REQ_RESTART: begin
								pos_q     <= 9'd0;
								col_q     <= 3'd0;
								first_q   <= 1'b0;
								pausing_q <= 1'b0;
								pstart_q  <= 32'd0;
								last_q    <= 32'd0;
							end
							default: ;
						endcase
					end
				end
				S_EVAL: begin
					if (!step_due) begin
						stat_q  <= ST_WAITED;
						state_q <= S_STAT;
					end else if (pausing_q) begin
						state_q <= S_STAT;
						if (pause_done) begin
							stat_q    <= ST_ENDED;
							pos_q     <= 9'd0;
							col_q     <= 3'd0;
							first_q   <= 1'b0;
							pausing_q <= 1'b0;
							pstart_q  <= 32'd0;
							last_q    <= 32'd0;
						end else begin
							stat_q <= ST_PAUSED;
							last_q <= now_q;
						end
					end else begin
						last_q <= now_q;
						if (!first_q) begin
							first_q <= 1'b1;
							if (at_end) begin
								pausing_q <= 1'b1;
								pstart_q  <= now_q;
							end
							blank_q <= blank_now;
							fcnt_q  <= 4'd0;
							post_q  <= 1'b0;
							state_q <= S_FETCH;
						end else begin
							state_q <= S_SHIFT;
						end
					end
				end
				S_FETCH: begin
					if (!fcnt_q[3]) begin
						fcnt_q <= fcnt_q + 4'd1;
					end
					if (cap_v_s1) begin
						frame_q[{1'b1, cap_row_s1}] <= blank_q ? 8'd0 : ram_rdata;
						if (cap_row_s1 == 3'd7) begin
							pos_q   <= pos_q + 9'd1;
							emit_q  <= 3'd0;
							state_q <= post_q ? S_EMIT : S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					for (int i = 0; i < 16; i++) begin
						frame_q[i] <= shifted[i];
					end
					col_q  <= col_q + 3'd1;
					emit_q <= 3'd0;
					if (col_q == 3'd7) begin
						if (at_end) begin
							pausing_q <= 1'b1;
							pstart_q  <= now_q;
						end
						blank_q <= blank_now;
						fcnt_q  <= 4'd0;
						post_q  <= 1'b1;
						state_q <= S_FETCH;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'd7) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_STAT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= res_load || (res_valid_q && !res.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			if (state_q == S_EMIT) begin
				res_data_q.status    <= ST_MOVED;
				res_data_q.row_index <= emit_q;
				res_data_q.row_byte  <= rd_row;
				res_data_q.last      <= (emit_q == 3'd7);
			end else begin
				res_data_q.status    <= stat_q;
				res_data_q.row_index <= 3'd0;
				res_data_q.row_byte  <= 8'd0;
				res_data_q.last      <= 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	// the closing row of a move sits at the last display address
	a_move_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.data.status == ST_MOVED) && res.data.last
		|-> res.data.row_index == 3'd7)
		else $error("move ended on wrong row");

	// wait, pause and end results are single, empty items
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.data.status != ST_MOVED)
		|-> res.data.last && (res.data.row_byte == 8'd0) && (res.data.row_index == 3'd0))
		else $error("non-move result not single");

	// each shift advances the column count by one
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |=> col_q == $past(col_q) + 3'd1)
		else $error("column count slipped");

	// memory read data is only captured during a fetch
	a_capture_in_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		cap_v_s1 |-> state_q == S_FETCH)
		else $error("glyph capture outside fetch");
`endif

endmodule
